### hw/rtl/tlpma_pkg.sv
// constants, payload types and sequencer states for the two-level page map allocator
// no dependencies

package tlpma_pkg;

  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int DIR_AW        = $clog2(DIR_ENTRIES);
  localparam int TAB_AW        = $clog2(TABLE_ENTRIES);
  localparam int TBL_WORDS     = DIR_ENTRIES * TABLE_ENTRIES;
  localparam int TBL_AW        = $clog2(TBL_WORDS);

  localparam int IDX_BITS    = 10;
  localparam int FRAME_W     = 20;
  localparam int WORD_W      = 32;
  localparam int FRAME_SHIFT = 12;
  localparam int FLAG_BITS   = 3;

  localparam logic [FLAG_BITS-1:0] ENTRY_FLAGS = 3'b111;

  localparam logic ACT_MAP   = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  typedef struct packed {
    logic               action;
    logic [FRAME_W-1:0] virt_page;
    logic [FRAME_W-1:0] phys_frame;
    logic [FRAME_W-1:0] table_frame;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [WORD_W-1:0] virt_addr;
    logic              table_taken;
    logic              frame_taken;
    logic [WORD_W-1:0] entry_written;
  } out_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIR_RD,
    ST_DIR_CHK,
    ST_SCAN_TAB,
    ST_CLR,
    ST_WRITE,
    ST_NONE
  } state_t;

endpackage

### hw/rtl/two_level_page_map_allocator_top.sv
// page directory and page tables with map and first-free allocate operations
// depends on tlpma_pkg

// After reset the block clears its page directory, one entry per cycle, with busy high.
// An item is taken when start is high and busy is low; busy stays high until its result
// has been produced. A map reads its directory entry, checks it and writes the page
// table entry, first creating and clearing a new page table when the slot is empty. An
// allocate reads and checks each directory entry in turn and scans each present table at
// one table-memory read a cycle, then adds the table clear if the page falls in an empty
// directory slot; one table-memory port sets that pace. The result
// appears on out_data for exactly one cycle with out_valid high and must be taken then:
// there is no back-pressure on the result side.

module two_level_page_map_allocator_top
  import tlpma_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam logic [DIR_AW-1:0] DIR_LAST = DIR_AW'(DIR_ENTRIES - 1);
  localparam logic [TAB_AW-1:0] TAB_LAST = TAB_AW'(TABLE_ENTRIES - 1);

  function automatic logic [TBL_AW-1:0] tbl_addr(logic [DIR_AW-1:0] d, logic [TAB_AW-1:0] t);
    tbl_addr = TBL_AW'(d) * TBL_AW'(TABLE_ENTRIES) + TBL_AW'(t);
  endfunction

  state_t            state_r, state_nxt;
  in_t               in_r, in_nxt;
  logic [DIR_AW-1:0] dir_r, dir_nxt;
  logic [TAB_AW-1:0] tab_r, tab_nxt;
  logic [TAB_AW-1:0] clr_r, clr_nxt;
  logic [TAB_AW-1:0] tab_rd_r, tab_rd_nxt;
  logic [TAB_AW-1:0] tab_chk_r, tab_chk_nxt;
  logic              tab_vld_r, tab_vld_nxt;
  logic              rd_more_r, rd_more_nxt;
  logic              created_r, created_nxt;
  out_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [WORD_W-1:0] dir_mem [DIR_ENTRIES];
  logic [WORD_W-1:0] tbl_mem [TBL_WORDS];
  logic [WORD_W-1:0] dir_q, tbl_q;
  logic              dir_we, tbl_we;
  logic [WORD_W-1:0] dir_wdata, tbl_wdata;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;

  logic [IDX_BITS-1:0] vp_dir, vp_tab;
  logic                vp_ok;
  logic [WORD_W-1:0]   entry_word;

  assign vp_dir = in_data.virt_page[2*IDX_BITS-1:IDX_BITS];
  assign vp_tab = in_data.virt_page[IDX_BITS-1:0];
  assign vp_ok  = ({1'b0, vp_dir} < (IDX_BITS+1)'(DIR_ENTRIES))
               && ({1'b0, vp_tab} < (IDX_BITS+1)'(TABLE_ENTRIES));
  assign entry_word = {in_r.phys_frame, {(FRAME_SHIFT-FLAG_BITS){1'b0}}, ENTRY_FLAGS};
  assign tbl_raddr  = tbl_addr(dir_r, tab_rd_r);

  // memories
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_r] <= dir_wdata;
    end
    dir_q <= dir_mem[dir_r];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      dir_r       <= '0;
      tab_vld_r   <= 1'b0;
      rd_more_r   <= 1'b0;
      created_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      tab_vld_r   <= tab_vld_nxt;
      rd_more_r   <= rd_more_nxt;
      created_r   <= created_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    tab_r     <= tab_nxt;
    clr_r     <= clr_nxt;
    tab_rd_r  <= tab_rd_nxt;
    tab_chk_r <= tab_chk_nxt;
    out_r     <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    dir_nxt       = dir_r;
    tab_nxt       = tab_r;
    clr_nxt       = clr_r;
    tab_rd_nxt    = tab_rd_r;
    tab_chk_nxt   = tab_chk_r;
    tab_vld_nxt   = tab_vld_r;
    rd_more_nxt   = rd_more_r;
    created_nxt   = created_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    dir_we        = 1'b0;
    dir_wdata     = '0;
    tbl_we        = 1'b0;
    tbl_wdata     = '0;
    tbl_waddr     = tbl_addr(dir_r, clr_r);

    unique case (state_r)
      ST_INIT: begin
        dir_we  = 1'b1;
        dir_nxt = dir_r + 1'b1;
        if (dir_r == DIR_LAST) begin
          dir_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          in_nxt      = in_data;
          created_nxt = 1'b0;
          if (in_data.action == ACT_ALLOC) begin
            dir_nxt   = '0;
            state_nxt = ST_DIR_RD;
          end else if (vp_ok) begin
            dir_nxt   = DIR_AW'(vp_dir);
            tab_nxt   = TAB_AW'(vp_tab);
            state_nxt = ST_DIR_RD;
          end else begin
            state_nxt = ST_NONE;
          end
        end
      end
      ST_DIR_RD: begin
        state_nxt = ST_DIR_CHK;
      end
      ST_DIR_CHK: begin
        tab_vld_nxt = 1'b0;
        if (dir_q == '0) begin
          // empty slot: new table from table_frame
          dir_we      = 1'b1;
          dir_wdata   = {in_r.table_frame, {(FRAME_SHIFT-FLAG_BITS){1'b0}}, ENTRY_FLAGS};
          created_nxt = 1'b1;
          clr_nxt     = '0;
          if (in_r.action == ACT_ALLOC) begin
            tab_nxt = '0;
          end
          state_nxt = ST_CLR;
        end else if (in_r.action == ACT_MAP) begin
          state_nxt = ST_WRITE;
        end else begin
          tab_rd_nxt  = '0;
          rd_more_nxt = 1'b1;
          state_nxt   = ST_SCAN_TAB;
        end
      end
      ST_SCAN_TAB: begin
        // read at tab_rd_r while checking the word read last cycle
        priority if (tab_vld_r && tbl_q == '0) begin
          tab_nxt     = tab_chk_r;
          tab_vld_nxt = 1'b0;
          state_nxt   = ST_WRITE;
        end else if (tab_vld_r && tab_chk_r == TAB_LAST) begin
          tab_vld_nxt = 1'b0;
          if (dir_r == DIR_LAST) begin
            state_nxt = ST_NONE;
          end else begin
            dir_nxt   = dir_r + 1'b1;
            state_nxt = ST_DIR_RD;
          end
        end else begin
          tab_chk_nxt = tab_rd_r;
          tab_vld_nxt = rd_more_r;
          if (rd_more_r) begin
            tab_rd_nxt  = tab_rd_r + 1'b1;
            rd_more_nxt = (tab_rd_r != TAB_LAST);
          end
        end
      end
      ST_CLR: begin
        tbl_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == TAB_LAST) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        tbl_we                = 1'b1;
        tbl_waddr             = tbl_addr(dir_r, tab_r);
        tbl_wdata             = entry_word;
        out_nxt.found         = 1'b1;
        out_nxt.virt_addr     = {IDX_BITS'(dir_r), IDX_BITS'(tab_r), {FRAME_SHIFT{1'b0}}};
        out_nxt.table_taken   = created_r;
        out_nxt.frame_taken   = 1'b1;
        out_nxt.entry_written = entry_word;
        out_valid_nxt         = 1'b1;
        state_nxt             = ST_IDLE;
      end
      ST_NONE: begin
        out_nxt       = '0;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data == '0)
    else $error("miss result has nonzero fields");

  a_frame_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.frame_taken == out_data.found)
    else $error("frame_taken disagrees with found");

  a_table_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_taken |-> out_data.found)
    else $error("table taken without a mapping");

endmodule

### bench/two_level_page_map_allocator_top_test.sv
// self-checking bench for the two-level page map allocator: maps and first-free
// allocations checked against a behavioral page directory and page tables
// depends on tlpma_pkg and two_level_page_map_allocator_top

module two_level_page_map_allocator_top_test
  import tlpma_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 565;
  localparam int QUIET_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 50;
  localparam int BURST_FIRST  = 300;
  localparam int BURST_LAST   = 400;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  two_level_page_map_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  bit [WORD_W-1:0] dir_word [DIR_ENTRIES];
  bit [WORD_W-1:0] tbl_word [TBL_WORDS];

  in_t  pending_requests [$];
  out_t expected_mappings [$];

  int items_offered  = 0;
  int items_accepted = 0;
  int quiet_cycles   = 0;
  int errors         = 0;
  int results_seen   = 0;
  int maps_taken     = 0;
  int allocs_taken   = 0;
  int tables_made    = 0;

  function automatic out_t predict_page_map(in_t it);
    out_t r;
    int d;
    int t;
    int dsel;
    int tsel;
    bit hit;
    logic [WORD_W-1:0] entry;
    r = '0;
    hit = 1'b0;
    dsel = 0;
    tsel = 0;
    if (it.action == ACT_MAP) begin
      dsel = int'(it.virt_page[2*IDX_BITS-1:IDX_BITS]);
      tsel = int'(it.virt_page[IDX_BITS-1:0]);
      hit = (dsel < DIR_ENTRIES) && (tsel < TABLE_ENTRIES);
    end else begin
      for (d = 0; d < DIR_ENTRIES && !hit; d++) begin
        if (dir_word[d] == '0) begin
          dsel = d;
          tsel = 0;
          hit = 1'b1;
        end else begin
          for (t = 0; t < TABLE_ENTRIES && !hit; t++) begin
            if (tbl_word[d*TABLE_ENTRIES + t] == '0) begin
              dsel = d;
              tsel = t;
              hit = 1'b1;
            end
          end
        end
      end
    end
    if (hit) begin
      if (dir_word[dsel] == '0) begin
        dir_word[dsel] = {it.table_frame, {(FRAME_SHIFT-FLAG_BITS){1'b0}}, ENTRY_FLAGS};
        for (t = 0; t < TABLE_ENTRIES; t++)
          tbl_word[dsel*TABLE_ENTRIES + t] = '0;
        r.table_taken = 1'b1;
      end
      entry = {it.phys_frame, {(FRAME_SHIFT-FLAG_BITS){1'b0}}, ENTRY_FLAGS};
      tbl_word[dsel*TABLE_ENTRIES + tsel] = entry;
      r.found = 1'b1;
      r.frame_taken = 1'b1;
      r.entry_written = entry;
      r.virt_addr = (WORD_W'(dsel) << (FRAME_SHIFT + IDX_BITS)) | (WORD_W'(tsel) << FRAME_SHIFT);
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    errors++;
    $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, field, want, got);
  endtask

  // driver: new item at the falling edge, held until taken
  always @(negedge clk) begin
    if (rst_n && (!start || items_accepted == items_offered)) begin
      if (pending_requests.size() != 0 &&
          ((items_offered >= BURST_FIRST && items_offered < BURST_LAST) ||
           $urandom_range(0, 99) >= 31)) begin
        start <= 1'b1;
        in_data <= pending_requests.pop_front();
        items_offered++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results checked first, then the accepted item is predicted
  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (expected_mappings.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %p", $time, out_data);
        end else begin
          want = expected_mappings.pop_front();
          if (out_data.found !== want.found)
            report_mismatch("found", WORD_W'(want.found), WORD_W'(out_data.found));
          if (out_data.virt_addr !== want.virt_addr)
            report_mismatch("virt_addr", want.virt_addr, out_data.virt_addr);
          if (out_data.table_taken !== want.table_taken)
            report_mismatch("table_taken", WORD_W'(want.table_taken),
                            WORD_W'(out_data.table_taken));
          if (out_data.frame_taken !== want.frame_taken)
            report_mismatch("frame_taken", WORD_W'(want.frame_taken),
                            WORD_W'(out_data.frame_taken));
          if (out_data.entry_written !== want.entry_written)
            report_mismatch("entry_written", want.entry_written, out_data.entry_written);
        end
      end
      if (start && !busy) begin
        want = predict_page_map(in_data);
        expected_mappings.push_back(want);
        items_accepted++;
        if (in_data.action == ACT_MAP) maps_taken++;
        else allocs_taken++;
        if (want.table_taken) tables_made++;
      end
      if (out_valid || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic queue_request(logic act, logic [FRAME_W-1:0] vpage,
                               logic [FRAME_W-1:0] phys, logic [FRAME_W-1:0] tframe);
    in_t it;
    it.action = act;
    it.virt_page = vpage;
    it.phys_frame = phys;
    it.table_frame = tframe;
    pending_requests.push_back(it);
  endtask

  task automatic queue_random_request();
    logic [IDX_BITS-1:0] dsel;
    logic [IDX_BITS-1:0] tsel;
    logic [FRAME_W-1:0]  tframe;
    logic [FRAME_W-1:0]  vpage;
    vpage = FRAME_W'($urandom);
    tframe = FRAME_W'($urandom);
    case ($urandom_range(0, 19))
      0: tframe = '0;
      1: tframe = '1;
      default: ;
    endcase
    if ($urandom_range(0, 99) < 45) begin
      queue_request(ACT_ALLOC, vpage, FRAME_W'($urandom), tframe);
    end else begin
      // mostly a few directory slots, so that maps land in existing tables
      if ($urandom_range(0, 99) < 85)
        dsel = $urandom_range(0, 1) ? IDX_BITS'($urandom_range(0, 3))
                                    : IDX_BITS'(DIR_ENTRIES - 1 - $urandom_range(0, 1));
      else
        dsel = vpage[2*IDX_BITS-1:IDX_BITS];
      // small table indexes punch holes near the front of the allocation scan
      tsel = $urandom_range(0, 1) ? IDX_BITS'($urandom_range(0, 63)) : vpage[IDX_BITS-1:0];
      queue_request(ACT_MAP, {dsel, tsel}, FRAME_W'($urandom), tframe);
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || items_accepted != items_offered ||
           expected_mappings.size() != 0)
      @(negedge clk);
  endtask

  initial begin : stimulus
    int i;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // first allocation creates a table from frame zero in an empty directory
    queue_request(ACT_ALLOC, 20'h00000, 20'h00000, 20'h00000);
    queue_request(ACT_ALLOC, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    queue_request(ACT_MAP,   20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    queue_request(ACT_MAP,   20'h00000, 20'h12345, 20'hFFFFF);
    queue_request(ACT_MAP,   20'h00005, 20'h00000, 20'hAAAAA);
    queue_request(ACT_ALLOC, 20'h55555, 20'hAAAAA, 20'h55555);
    queue_request(ACT_ALLOC, 20'hAAAAA, 20'h55555, 20'hAAAAA);
    queue_request(ACT_ALLOC, 20'h00000, 20'h00001, 20'h00000);
    queue_request(ACT_ALLOC, 20'hFFFFF, 20'h80000, 20'hFFFFF);
    queue_request(ACT_MAP,   20'h00400, 20'h55555, 20'h00000);
    queue_request(ACT_MAP,   20'h007FF, 20'hAAAAA, 20'hFFFFF);
    queue_request(ACT_MAP,   20'hAAAAA, 20'h55555, 20'hAAAAA);
    queue_request(ACT_MAP,   20'h55555, 20'hAAAAA, 20'h55555);
    queue_request(ACT_MAP,   20'hFFFFF, 20'h00000, 20'h00000);
    queue_request(ACT_MAP,   20'hFFC00, 20'h00001, 20'h00000);
    queue_request(ACT_ALLOC, 20'h00000, 20'hFFFFF, 20'h00000);
    wait_drained();

    for (i = 0; i < RANDOM_ITEMS / 2; i++) queue_random_request();
    wait_drained();
    for (i = RANDOM_ITEMS / 2; i < RANDOM_ITEMS; i++) queue_random_request();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d items taken (%0d maps, %0d allocations), %0d results checked",
             items_accepted, maps_taken, allocs_taken, results_seen);
    $display("%0d page tables created, %0d mismatches", tables_made, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
